// ===== rtl/ochp_pkg.sv =====
// ----------------------------------------------------------------------------
// ochp_pkg
// Shared types, constants and the hash mixing step of the operation cache.
// ----------------------------------------------------------------------------
package ochp_pkg;

  localparam int unsigned OP_W   = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;

  // Hash: seed, bytes folded per cycle, byte counts per request kind
  localparam logic [WORD_W-1:0] HASH_SEED      = 32'hdeadbeef;
  localparam int unsigned       HASH_PER_CYCLE = 3;
  localparam int unsigned       HASH_BYTES_BIN = 9;
  localparam int unsigned       HASH_BYTES_UN  = 5;

  // Remainder unit takes one hex digit of the hash per cycle
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned DIGITS  = WORD_W / DIGIT_W;

  // Number of consecutive slots visited by one request
  localparam int unsigned PROBES = 3;

  // Request codes
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // Op code of an empty slot
  localparam logic [OP_W-1:0] OP_EMPTY = '0;

  typedef struct packed {
    logic              req_type;
    logic              is_binary;
    logic [OP_W-1:0]   op_code;
    logic [WORD_W-1:0] operand_p;
    logic [WORD_W-1:0] operand_q;
    logic [WORD_W-1:0] answer_in;
  } req_t;

  typedef struct packed {
    logic [OP_W-1:0]   op_code;
    logic [WORD_W-1:0] operand_p;
    logic [WORD_W-1:0] operand_q;
    logic [WORD_W-1:0] answer;
  } slot_t;

  // h * 31 xor byte, modulo 2^32
  function automatic logic [WORD_W-1:0] mix_byte(input logic [WORD_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] h31;
    h31 = {h[WORD_W-6:0], 5'd0} - h;
    return h31 ^ {{(WORD_W-BYTE_W){1'b0}}, b};
  endfunction

endpackage

// ===== rtl/ochp_req_if.sv =====
// ----------------------------------------------------------------------------
// ochp_req_if
// Request channel of the operation cache: valid/ready plus request fields.
// ----------------------------------------------------------------------------
interface ochp_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic                         is_binary;
  logic [ochp_pkg::OP_W-1:0]    op_code;
  logic [ochp_pkg::WORD_W-1:0]  operand_p;
  logic [ochp_pkg::WORD_W-1:0]  operand_q;
  logic [ochp_pkg::WORD_W-1:0]  answer_in;

  modport source (
    output valid, req_type, is_binary, op_code, operand_p, operand_q, answer_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, is_binary, op_code, operand_p, operand_q, answer_in,
    output ready
  );
endinterface

// ===== rtl/ochp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ochp_rsp_if
// Result channel of the operation cache: valid/ready plus lookup outcome.
// ----------------------------------------------------------------------------
interface ochp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [ochp_pkg::WORD_W-1:0]  answer_out;

  modport source (
    output valid, hit, answer_out,
    input  ready
  );

  modport sink (
    input  valid, hit, answer_out,
    output ready
  );
endinterface

// ===== rtl/op_cache_hash_probe_core.sv =====
// ----------------------------------------------------------------------------
// op_cache_hash_probe_core
// Result cache for decision-diagram operations with three-slot linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries lookups and inserts (valid/ready). A transfer takes place at
//   a rising edge with valid and ready high. Each lookup gives one transfer on
//   rsp_o (hit, answer_out); an insert gives none.
//   The home slot unit does 3-byte hash folding, then takes one hex digit of
//   the remainder per cycle. This unit sets the throughput: it takes a new
//   request only after handing the previous one off. The probe engine
//   overlaps with it: three back-to-back reads of the slot memory, then a
//   decision cycle that writes back an insert or loads the result register.
//   After reset the engine sweeps the op field of every slot to empty, one
//   slot per cycle; req_i.ready stays low until it is done. A result waits
//   in its output register while rsp_o is stalled; the next request is
//   hashed meanwhile and the engine holds only when a second lookup result
//   is ready before the first has gone out.
// ----------------------------------------------------------------------------
module op_cache_hash_probe_core #(
  parameter int unsigned TABLE_SIZE = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ochp_req_if.sink    req_i,
  ochp_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
  localparam int unsigned PCNT_W = $clog2(ochp_pkg::PROBES);
  localparam int unsigned WORD_W = ochp_pkg::WORD_W;
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(TABLE_SIZE - 1);
  localparam logic [PCNT_W-1:0] LAST_PROBE = PCNT_W'(ochp_pkg::PROBES - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_e;

  // Next slot, wrapping at the end of the table
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] a);
    return (a == LAST_IDX) ? '0 : a + 1'b1;
  endfunction

  // Home slot unit handshake
  ochp_pkg::req_t    in_req;
  logic              ix_in_valid, ix_in_ready;
  logic              ix_out_valid, ix_out_ready;
  ochp_pkg::req_t    ix_req;
  logic [IDX_W-1:0]  ix_home;
  logic              clear_done;

  // Engine registers
  state_e            state_q, state_d;
  logic [PCNT_W-1:0] cnt_q, cnt_d;
  ochp_pkg::req_t    req_q, req_d;
  logic [IDX_W-1:0]  home_q, home_d;
  logic [IDX_W-1:0]  addr_q, addr_d;
  logic              found_q, found_d;
  logic [WORD_W-1:0] ans_q, ans_d;
  logic              empty_found_q, empty_found_d;
  logic [IDX_W-1:0]  empty_addr_q, empty_addr_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic              rsp_hit_q, rsp_hit_d;
  logic [WORD_W-1:0] rsp_ans_q, rsp_ans_d;

  // Slot memory
  ochp_pkg::slot_t   slot_mem [TABLE_SIZE];
  ochp_pkg::slot_t   rd_data_q;
  logic [IDX_W-1:0]  rd_addr_q;
  logic              mem_re, mem_we;
  logic [IDX_W-1:0]  mem_raddr, mem_waddr;
  ochp_pkg::slot_t   mem_wdata;

  // Probe evaluation
  logic              cur_empty, cur_match;
  logic              fin_found;
  logic [WORD_W-1:0] fin_ans;
  logic [IDX_W-1:0]  fin_slot;

  assign clear_done = (state_q != ST_CLEAR);

  // Gather request fields; hold requests off during the clearing sweep
  always_comb begin
    in_req.req_type  = req_i.req_type;
    in_req.is_binary = req_i.is_binary;
    in_req.op_code   = req_i.op_code;
    in_req.operand_p = req_i.operand_p;
    in_req.operand_q = req_i.operand_q;
    in_req.answer_in = req_i.answer_in;
  end

  assign ix_in_valid = req_i.valid && clear_done;
  assign req_i.ready = ix_in_ready && clear_done;

  ochp_index #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_index (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ix_in_valid),
    .in_ready_o  (ix_in_ready),
    .in_req_i    (in_req),
    .out_valid_o (ix_out_valid),
    .out_ready_i (ix_out_ready),
    .out_req_o   (ix_req),
    .out_home_o  (ix_home)
  );

  // Compare the slot read last cycle against the request
  assign cur_empty = (rd_data_q.op_code == ochp_pkg::OP_EMPTY);
  assign cur_match = !cur_empty
                  && (rd_data_q.op_code == req_q.op_code)
                  && (rd_data_q.operand_p == req_q.operand_p)
                  && (!req_q.is_binary || (rd_data_q.operand_q == req_q.operand_q));

  // Final outcome including the third probe
  assign fin_found = found_q || cur_match;
  assign fin_ans   = found_q ? ans_q : rd_data_q.answer;
  assign fin_slot  = empty_found_q ? empty_addr_q : (cur_empty ? rd_addr_q : home_q);

  // Probe sequencer
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    req_d         = req_q;
    home_d        = home_q;
    addr_d        = addr_q;
    found_d       = found_q;
    ans_d         = ans_q;
    empty_found_d = empty_found_q;
    empty_addr_d  = empty_addr_q;
    rsp_hit_d     = rsp_hit_q;
    rsp_ans_d     = rsp_ans_q;
    rsp_valid_d   = rsp_valid_q && !rsp_o.ready;
    ix_out_ready  = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = addr_q;
    mem_we        = 1'b0;
    mem_waddr     = addr_q;
    mem_wdata     = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        addr_d = next_idx(addr_q);
        if (addr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ix_out_ready = 1'b1;
        if (ix_out_valid) begin
          req_d         = ix_req;
          home_d        = ix_home;
          addr_d        = ix_home;
          mem_re        = 1'b1;
          mem_raddr     = ix_home;
          found_d       = 1'b0;
          empty_found_d = 1'b0;
          cnt_d         = PCNT_W'(1);
          state_d       = ST_PROBE;
        end
      end
      ST_PROBE: begin
        mem_re    = 1'b1;
        mem_raddr = next_idx(addr_q);
        addr_d    = next_idx(addr_q);
        if (!found_q && cur_match) begin
          found_d = 1'b1;
          ans_d   = rd_data_q.answer;
        end
        if (!empty_found_q && cur_empty) begin
          empty_found_d = 1'b1;
          empty_addr_d  = rd_addr_q;
        end
        if (cnt_q == LAST_PROBE) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (req_q.req_type == ochp_pkg::REQ_INSERT) begin
          // Write back into first empty probe slot, else the home slot
          if (req_q.op_code != ochp_pkg::OP_EMPTY) begin
            mem_we              = 1'b1;
            mem_waddr           = fin_slot;
            mem_wdata.op_code   = req_q.op_code;
            mem_wdata.operand_p = req_q.operand_p;
            mem_wdata.operand_q = req_q.operand_q;
            mem_wdata.answer    = req_q.answer_in;
          end
          state_d = ST_IDLE;
        end else if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_hit_d   = fin_found;
          rsp_ans_d   = fin_found ? fin_ans : '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      cnt_q         <= '0;
      req_q         <= '0;
      home_q        <= '0;
      addr_q        <= '0;
      found_q       <= 1'b0;
      ans_q         <= '0;
      empty_found_q <= 1'b0;
      empty_addr_q  <= '0;
      rsp_valid_q   <= 1'b0;
      rsp_hit_q     <= 1'b0;
      rsp_ans_q     <= '0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      req_q         <= req_d;
      home_q        <= home_d;
      addr_q        <= addr_d;
      found_q       <= found_d;
      ans_q         <= ans_d;
      empty_found_q <= empty_found_d;
      empty_addr_q  <= empty_addr_d;
      rsp_valid_q   <= rsp_valid_d;
      rsp_hit_q     <= rsp_hit_d;
      rsp_ans_q     <= rsp_ans_d;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= slot_mem[mem_raddr];
      rd_addr_q <= mem_raddr;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit        = rsp_hit_q;
  assign rsp_o.answer_out = rsp_ans_q;

  // Writes happen only in the clearing sweep or the decision cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_DONE))
    else $error("slot write outside clear or decision cycle");

  // A decision-cycle write belongs to an insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == ST_DONE) |-> (req_q.req_type == ochp_pkg::REQ_INSERT))
    else $error("slot write for a lookup");

  // No request transfer while the table is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !req_i.ready)
    else $error("request accepted during clearing sweep");

  // A new result only comes out of the decision cycle of a lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q == ST_DONE)
                            && $past(req_q.req_type == ochp_pkg::REQ_LOOKUP)))
    else $error("result without a finished lookup");

  // Reads never overlap a write in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> !mem_we)
    else $error("read and write of slot memory in the same cycle");

endmodule

// ===== rtl/ochp_index.sv =====
// ----------------------------------------------------------------------------
// ochp_index
// Home slot unit: folds the request bytes into the 32-bit hash, three bytes
// per cycle, then reduces the hash modulo TABLE_SIZE one hex digit per cycle.
// ----------------------------------------------------------------------------
module ochp_index #(
  parameter int unsigned TABLE_SIZE = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ochp_pkg::req_t                in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ochp_pkg::req_t                out_req_o,
  output logic [$clog2(TABLE_SIZE)-1:0] out_home_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
  localparam int unsigned V_W    = IDX_W + ochp_pkg::DIGIT_W;
  localparam int unsigned CNT_W  = $clog2(ochp_pkg::DIGITS);
  localparam int unsigned BIDX_W = $clog2(ochp_pkg::HASH_BYTES_BIN + ochp_pkg::HASH_PER_CYCLE);
  localparam int unsigned WORD_W = ochp_pkg::WORD_W;
  localparam int unsigned DIGIT_W = ochp_pkg::DIGIT_W;

  localparam logic [CNT_W-1:0] LAST_STEP_BIN =
      CNT_W'((ochp_pkg::HASH_BYTES_BIN - 1) / ochp_pkg::HASH_PER_CYCLE);
  localparam logic [CNT_W-1:0] LAST_STEP_UN =
      CNT_W'((ochp_pkg::HASH_BYTES_UN - 1) / ochp_pkg::HASH_PER_CYCLE);
  localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(ochp_pkg::DIGITS - 1);

  typedef enum logic [1:0] {
    IX_IDLE,
    IX_HASH,
    IX_MOD,
    IX_DONE
  } ix_state_e;

  ix_state_e             state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  ochp_pkg::req_t        req_q, req_d;
  logic [WORD_W-1:0]     hash_q, hash_d;
  logic [IDX_W-1:0]      rem_q, rem_d;

  logic [ochp_pkg::BYTE_W-1:0] byte_seq [ochp_pkg::HASH_BYTES_BIN];
  logic [BIDX_W-1:0]     n_bytes;
  logic [CNT_W-1:0]      last_step;
  logic [WORD_W-1:0]     hash_step;
  logic [IDX_W-1:0]      rem_step;

  // Byte order: op, then operand p and q, most significant byte first
  always_comb begin
    byte_seq[0] = req_q.op_code;
    for (int b = 0; b < 4; b++) begin
      byte_seq[1 + b] = req_q.operand_p[WORD_W-1-8*b -: 8];
      byte_seq[5 + b] = req_q.operand_q[WORD_W-1-8*b -: 8];
    end
  end

  assign n_bytes   = req_q.is_binary ? BIDX_W'(ochp_pkg::HASH_BYTES_BIN)
                                     : BIDX_W'(ochp_pkg::HASH_BYTES_UN);
  assign last_step = req_q.is_binary ? LAST_STEP_BIN : LAST_STEP_UN;

  // Fold up to three bytes into the hash this cycle
  always_comb begin
    logic [BIDX_W-1:0] idx;
    hash_step = hash_q;
    idx       = '0;
    for (int j = 0; j < ochp_pkg::HASH_PER_CYCLE; j++) begin
      idx = BIDX_W'(cnt_q) * BIDX_W'(ochp_pkg::HASH_PER_CYCLE) + BIDX_W'(j);
      if (idx < n_bytes) begin
        hash_step = ochp_pkg::mix_byte(hash_step, byte_seq[idx]);
      end
    end
  end

  // Shift in one digit and subtract the largest multiple of the table size
  always_comb begin
    logic [V_W-1:0] v;
    logic [V_W-1:0] rem_full;
    logic [V_W-1:0] mult;
    v        = {rem_q, hash_q[WORD_W-1 -: DIGIT_W]};
    rem_full = v;
    mult     = '0;
    for (int k = 1; k < (1 << DIGIT_W); k++) begin
      mult = V_W'(k * TABLE_SIZE);
      if (v >= mult) begin
        rem_full = v - mult;
      end
    end
    rem_step = rem_full[IDX_W-1:0];
  end

  // Sequencer: accept, hash, reduce, hand off
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    req_d   = req_q;
    hash_d  = hash_q;
    rem_d   = rem_q;
    unique case (state_q)
      IX_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          if (!in_req_i.is_binary) begin
            req_d.operand_q = '0;
          end
          hash_d  = ochp_pkg::HASH_SEED;
          cnt_d   = '0;
          state_d = IX_HASH;
        end
      end
      IX_HASH: begin
        hash_d = hash_step;
        if (cnt_q == last_step) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = IX_MOD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      IX_MOD: begin
        rem_d  = rem_step;
        hash_d = {hash_q[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LAST_DIGIT) begin
          state_d = IX_DONE;
        end
      end
      IX_DONE: begin
        if (out_ready_i) begin
          state_d = IX_IDLE;
        end
      end
      default: state_d = IX_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IX_IDLE;
      cnt_q   <= '0;
      req_q   <= '0;
      hash_q  <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      req_q   <= req_d;
      hash_q  <= hash_d;
      rem_q   <= rem_d;
    end
  end

  assign in_ready_o  = (state_q == IX_IDLE);
  assign out_valid_o = (state_q == IX_DONE);
  assign out_req_o   = req_q;
  assign out_home_o  = rem_q;

endmodule

// ===== bench/op_cache_hash_probe_core_tb.sv =====
// ----------------------------------------------------------------------------
// op_cache_hash_probe_core_tb
// Self-checking bench for the three-slot linear-probe operation cache.
// A shadow table, updated by every insert transfer, predicts the hit flag
// and the answer of each lookup. Results are checked in order as they come.
// Stimulus covers empty slots, op code zero, unary versus binary matching,
// probe chains wrapping past the last slot, home overwrite, random traffic
// over colliding keys with random stalls on both channels, then streaming.
// ----------------------------------------------------------------------------
module op_cache_hash_probe_core_tb;

  localparam int unsigned TABLE_SIZE   = 4096;
  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned OP_W         = ochp_pkg::OP_W;
  localparam int unsigned WORD_W       = ochp_pkg::WORD_W;
  localparam int unsigned BYTE_W       = ochp_pkg::BYTE_W;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] answer;
  } lookup_result_t;

  typedef struct {
    logic              bin;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] q;
  } cache_key_t;

  logic clk = 1'b0;
  logic rst_n;
  logic quiet;
  int   fail_count = 0;

  // Shadow copy of the slot store and the lookups still waiting for a result
  ochp_pkg::slot_t shadow_slot [TABLE_SIZE];
  lookup_result_t  lookup_result_q [$];

  ochp_req_if req_if ();
  ochp_rsp_if rsp_if ();

  op_cache_hash_probe_core #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hash over op, p and (binary only) q, then reduce to a home slot
  function automatic logic [WORD_W-1:0] fold_byte(input logic [WORD_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    return (h * 32'd31) ^ {24'd0, b};
  endfunction

  function automatic int unsigned home_slot(input logic [OP_W-1:0] op,
                                            input logic [WORD_W-1:0] p,
                                            input logic [WORD_W-1:0] q,
                                            input logic bin);
    logic [WORD_W-1:0] h;
    h = ochp_pkg::HASH_SEED;
    h = fold_byte(h, op);
    for (int i = 3; i >= 0; i--) h = fold_byte(h, p[8*i +: 8]);
    if (bin) begin
      for (int i = 3; i >= 0; i--) h = fold_byte(h, q[8*i +: 8]);
    end
    return h % TABLE_SIZE;
  endfunction

  // Apply one accepted request to the shadow table; queue a lookup outcome
  function automatic void predict_request(input ochp_pkg::req_t r);
    logic [WORD_W-1:0] q;
    int unsigned       home;
    int unsigned       idx;
    int unsigned       sel;
    bit                found;
    lookup_result_t    res;
    q     = r.is_binary ? r.operand_q : '0;
    home  = home_slot(r.op_code, r.operand_p, q, r.is_binary);
    idx   = home;
    sel   = home;
    found = 1'b0;
    if (r.req_type == ochp_pkg::REQ_INSERT) begin
      if (r.op_code == ochp_pkg::OP_EMPTY) return;
      for (int k = 0; k < ochp_pkg::PROBES; k++) begin
        if (!found && shadow_slot[idx].op_code == ochp_pkg::OP_EMPTY) begin
          found = 1'b1;
          sel   = idx;
        end
        idx = (idx + 1) % TABLE_SIZE;
      end
      shadow_slot[sel].op_code   = r.op_code;
      shadow_slot[sel].operand_p = r.operand_p;
      shadow_slot[sel].operand_q = q;
      shadow_slot[sel].answer    = r.answer_in;
      return;
    end
    res = '0;
    if (r.op_code != ochp_pkg::OP_EMPTY) begin
      for (int k = 0; k < ochp_pkg::PROBES; k++) begin
        if (!found && shadow_slot[idx].op_code != ochp_pkg::OP_EMPTY &&
            shadow_slot[idx].op_code == r.op_code &&
            shadow_slot[idx].operand_p == r.operand_p &&
            (!r.is_binary || shadow_slot[idx].operand_q == q)) begin
          found      = 1'b1;
          res.hit    = 1'b1;
          res.answer = shadow_slot[idx].answer;
        end
        idx = (idx + 1) % TABLE_SIZE;
      end
    end
    lookup_result_q.push_back(res);
  endfunction

  function automatic ochp_pkg::req_t make_req(input logic kind, input logic bin,
                                              input logic [OP_W-1:0] op,
                                              input logic [WORD_W-1:0] p,
                                              input logic [WORD_W-1:0] q,
                                              input logic [WORD_W-1:0] ans);
    ochp_pkg::req_t r;
    r.req_type  = kind;
    r.is_binary = bin;
    r.op_code   = op;
    r.operand_p = p;
    r.operand_q = q;
    r.answer_in = ans;
    return r;
  endfunction

  // Search random keys until one lands on the given home slot
  function automatic cache_key_t key_at_home(input int unsigned home, input logic bin);
    cache_key_t k;
    k.bin = bin;
    do begin
      k.op = OP_W'($urandom_range(1, 255));
      k.p  = $urandom;
      k.q  = bin ? $urandom : '0;
    end while (home_slot(k.op, k.p, k.q, k.bin) != home);
    return k;
  endfunction

  function automatic ochp_pkg::req_t insert_of(input cache_key_t k);
    return make_req(ochp_pkg::REQ_INSERT, k.bin, k.op, k.p, k.bin ? k.q : $urandom,
                    $urandom);
  endfunction

  function automatic ochp_pkg::req_t lookup_of(input cache_key_t k);
    return make_req(ochp_pkg::REQ_LOOKUP, k.bin, k.op, k.p, k.bin ? k.q : $urandom,
                    $urandom);
  endfunction

  // Drop valid; the argument sets how long it stays low
  task automatic req_idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
  endtask

  // Drive one request, hold it until the transfer, then update the shadow
  task automatic send_req(input ochp_pkg::req_t item);
    if (!quiet && $urandom_range(0, 4) == 0) req_idle($urandom_range(1, 12));
    @(negedge clk);
    req_if.valid     <= 1'b1;
    req_if.req_type  <= item.req_type;
    req_if.is_binary <= item.is_binary;
    req_if.op_code   <= item.op_code;
    req_if.operand_p <= item.operand_p;
    req_if.operand_q <= item.operand_q;
    req_if.answer_in <= item.answer_in;
    do begin
      @(posedge clk);
    end while (!req_if.ready);
    predict_request(item);
  endtask

  // Hold off the sender until every pending lookup has returned
  task automatic wait_results_drained();
    req_idle(1);
    while (lookup_result_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Empty table, op code zero, field extremes, unary/binary matching, wrap
  task automatic test_directed();
    cache_key_t chain [4];
    send_req(make_req(ochp_pkg::REQ_LOOKUP, 1'b0, 8'h01, 32'h0, 32'h0, 32'h0));
    send_req(make_req(ochp_pkg::REQ_LOOKUP, 1'b1, 8'hff, 32'hffffffff, 32'hffffffff,
                      32'hffffffff));
    send_req(make_req(ochp_pkg::REQ_INSERT, 1'b0, 8'hff, 32'hffffffff, 32'hffffffff,
                      32'hffffffff));
    send_req(make_req(ochp_pkg::REQ_LOOKUP, 1'b0, 8'hff, 32'hffffffff, 32'h0, 32'h0));
    send_req(make_req(ochp_pkg::REQ_LOOKUP, 1'b1, 8'hff, 32'hffffffff, 32'h0, 32'h0));
    send_req(make_req(ochp_pkg::REQ_INSERT, 1'b1, 8'h01, 32'h0, 32'h0, 32'h0));
    send_req(make_req(ochp_pkg::REQ_LOOKUP, 1'b1, 8'h01, 32'h0, 32'h0, 32'hffffffff));
    send_req(make_req(ochp_pkg::REQ_LOOKUP, 1'b1, 8'h01, 32'h0, 32'h1, 32'h0));
    send_req(make_req(ochp_pkg::REQ_INSERT, 1'b1, 8'h80, 32'h80000000, 32'hffffffff,
                      32'ha5a5a5a5));
    send_req(make_req(ochp_pkg::REQ_LOOKUP, 1'b1, 8'h80, 32'h80000000, 32'hffffffff,
                      32'h0));
    // op code zero: insert is dropped, lookup always misses
    send_req(make_req(ochp_pkg::REQ_INSERT, 1'b0, ochp_pkg::OP_EMPTY, 32'h5, 32'h0,
                      32'h12345678));
    send_req(make_req(ochp_pkg::REQ_LOOKUP, 1'b0, ochp_pkg::OP_EMPTY, 32'h5, 32'h0,
                      32'h0));
    send_req(make_req(ochp_pkg::REQ_LOOKUP, 1'b1, ochp_pkg::OP_EMPTY, 32'h0, 32'h0,
                      32'h0));
    // Four keys on the last slot: fill it, wrap to 0 and 1, overwrite home
    for (int i = 0; i < 4; i++) chain[i] = key_at_home(TABLE_SIZE - 1, i[0]);
    foreach (chain[i]) send_req(insert_of(chain[i]));
    foreach (chain[i]) send_req(lookup_of(chain[i]));
  endtask

  // Mostly inserts and lookups over a pool of colliding keys, some noise
  task automatic test_random_mix(input int unsigned n_items);
    cache_key_t     pool [$];
    cache_key_t     k;
    ochp_pkg::req_t r;
    int unsigned    pick;
    int unsigned    home;
    for (int i = 0; i < 16; i++) begin
      k.bin = 1'($urandom_range(0, 1));
      k.op  = OP_W'($urandom_range(1, 255));
      k.p   = $urandom;
      k.q   = k.bin ? $urandom : '0;
      pool.push_back(k);
    end
    for (int c = 0; c < 3; c++) begin
      home = (c == 1) ? TABLE_SIZE - 2 : $urandom_range(0, TABLE_SIZE - 1);
      for (int i = 0; i < 6; i++) begin
        pool.push_back(key_at_home(home, 1'($urandom_range(0, 1))));
      end
    end
    for (int unsigned n = 0; n < n_items; n++) begin
      if (n == n_items / 2) wait_results_drained();
      pick = $urandom_range(0, 99);
      k    = pool[$urandom_range(0, pool.size() - 1)];
      if (pick < 40) begin
        r = insert_of(k);
      end else if (pick < 85) begin
        r = lookup_of(k);
        // Cross-probe a key with the other arity
        if ($urandom_range(0, 7) == 0) begin
          r.is_binary = ~k.bin;
          r.operand_q = $urandom_range(0, 1) ? 32'h0 : $urandom;
        end
      end else begin
        r = make_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     OP_W'($urandom), $urandom, $urandom, $urandom);
        if ($urandom_range(0, 3) == 0) r.op_code = ochp_pkg::OP_EMPTY;
      end
      send_req(r);
    end
  endtask

  // Back-to-back traffic with both sides always ready
  task automatic test_streaming(input int unsigned n_items);
    cache_key_t keys [8];
    int unsigned home;
    quiet = 1'b1;
    home  = $urandom_range(0, TABLE_SIZE - 1);
    foreach (keys[i]) keys[i] = key_at_home(home, 1'($urandom_range(0, 1)));
    for (int unsigned n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 1)) send_req(insert_of(keys[$urandom_range(0, 7)]));
      else send_req(lookup_of(keys[$urandom_range(0, 7)]));
    end
  endtask

  // Result-side stalls in random bursts
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest pending lookup
  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (lookup_result_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual hit %0b answer %h",
                 $time, rsp_if.hit, rsp_if.answer_out);
        fail_count++;
      end else begin
        want = lookup_result_q.pop_front();
        if (rsp_if.hit !== want.hit) begin
          $display("%0t: hit: expected %0b, actual %0b", $time, want.hit, rsp_if.hit);
          fail_count++;
        end
        if (rsp_if.answer_out !== want.answer) begin
          $display("%0t: answer_out: expected %h, actual %h",
                   $time, want.answer, rsp_if.answer_out);
          fail_count++;
        end
      end
    end
  end

  // Abort a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("op_cache_hash_probe_core: mismatch");
    $finish;
  end

  initial begin
    foreach (shadow_slot[i]) shadow_slot[i] = '0;
    rst_n            = 1'b0;
    quiet            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = ochp_pkg::REQ_LOOKUP;
    req_if.is_binary = 1'b0;
    req_if.op_code   = ochp_pkg::OP_EMPTY;
    req_if.operand_p = '0;
    req_if.operand_q = '0;
    req_if.answer_in = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_mix(380);
    test_streaming(200);

    req_idle(1);
    while (lookup_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && lookup_result_q.size() == 0) begin
      $display("op_cache_hash_probe_core: match");
    end else begin
      $display("op_cache_hash_probe_core: mismatch");
    end
    $finish;
  end

endmodule
